// ----- rtl/wcip_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wcip_pkg;

    localparam int CHAR_W  = 21;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 16;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int PROD_W  = VAL_W + BASE_W;

    localparam logic [CNT_W-1:0] MAX_STRING_LEN = 16'hFFFF;

    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

    localparam logic [VAL_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    localparam logic [CHAR_W-1:0] CH_NUL   = 21'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 21'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 21'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 21'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 21'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 21'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 21'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 21'h7A;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_ZEROX  = 3'd4,
        PH_DIGITS = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        logic               nul;
        logic               space;
        logic               plus;
        logic               minus;
        logic               zero;
        logic               ex;
        logic [DIGIT_W-1:0] digit;
    } t_char_class;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] consumed;
        logic             converted;
        logic             range_error;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/wcip_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wcip_classify (
    input  wire logic [wcip_pkg::CHAR_W-1:0] i_char,
    output wcip_pkg::t_char_class            o_cls
);

    always_comb begin
        o_cls.nul   = (i_char == wcip_pkg::CH_NUL);
        o_cls.space = (i_char == wcip_pkg::CH_SPACE) ||
                      (i_char >= wcip_pkg::CH_TAB && i_char <= wcip_pkg::CH_CR);
        o_cls.plus  = (i_char == wcip_pkg::CH_PLUS);
        o_cls.minus = (i_char == wcip_pkg::CH_MINUS);
        o_cls.zero  = (i_char == wcip_pkg::CH_0);
        o_cls.ex    = (i_char == wcip_pkg::CH_LX) || (i_char == wcip_pkg::CH_UX);
        // letters map to 10..35, anything else to a value no base accepts
        if (i_char >= wcip_pkg::CH_0 && i_char <= wcip_pkg::CH_9) begin
            o_cls.digit = wcip_pkg::DIGIT_W'(i_char[6:0] - wcip_pkg::CH_0[6:0]);
        end else if (i_char >= wcip_pkg::CH_LA && i_char <= wcip_pkg::CH_LZ) begin
            o_cls.digit = wcip_pkg::DIGIT_W'(i_char[6:0] - wcip_pkg::CH_LA[6:0] + 7'd10);
        end else if (i_char >= wcip_pkg::CH_UA && i_char <= wcip_pkg::CH_UZ) begin
            o_cls.digit = wcip_pkg::DIGIT_W'(i_char[6:0] - wcip_pkg::CH_UA[6:0] + 7'd10);
        end else begin
            o_cls.digit = wcip_pkg::DIGIT_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wcip_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wcip_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic                          i_start,
    input  wire wcip_pkg::t_char_class         i_cls,
    input  wire logic [wcip_pkg::BASE_W-1:0]   i_cfg_base,
    output logic                               o_res_valid,
    output wcip_pkg::t_result                  o_res
);

    wcip_pkg::t_phase                r_phase, n_phase;
    logic                            r_neg, n_neg;
    logic [wcip_pkg::BASE_W-1:0]     r_base, n_base;
    logic [wcip_pkg::VAL_W-1:0]      r_acc, n_acc;
    logic                            r_ovf, n_ovf;
    logic [wcip_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic [wcip_pkg::CNT_W-1:0]      r_end, n_end;
    logic                            r_any, n_any;

    logic                            fin;
    logic                            sign_path;
    logic                            do_take;
    logic                            bad_cfg;
    logic [wcip_pkg::BASE_W-1:0]     w_b;
    logic [wcip_pkg::VAL_W-1:0]      w_limit;
    logic [wcip_pkg::PROD_W-1:0]     w_sum;
    logic [wcip_pkg::VAL_W-1:0]      w_mag;

    assign bad_cfg = (i_cfg_base != wcip_pkg::BASE_AUTO && i_cfg_base < wcip_pkg::BASE_MIN) ||
                     (i_cfg_base > wcip_pkg::BASE_MAX);

    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_base      = r_base;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_end       = r_end;
        n_any       = r_any;
        fin         = 1'b0;
        sign_path   = 1'b0;
        do_take     = 1'b0;
        w_b         = wcip_pkg::BASE_DEC;
        w_limit     = wcip_pkg::POS_LIMIT;
        w_sum       = '0;
        w_mag       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            if (i_start) begin
                n_neg   = 1'b0;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_pos   = '0;
                n_end   = '0;
                n_any   = 1'b0;
                n_base  = i_cfg_base;
                n_phase = wcip_pkg::PH_SPACE;
            end

            if (i_start && bad_cfg) begin
                fin = 1'b1;
            end else if (n_phase == wcip_pkg::PH_IDLE || n_phase == wcip_pkg::PH_DONE) begin
                fin = 1'b0;
            end else if (n_pos >= wcip_pkg::MAX_STRING_LEN || i_cls.nul) begin
                fin = 1'b1;
            end else begin
                unique case (n_phase)
                    wcip_pkg::PH_SPACE: begin
                        if (i_cls.space) begin
                            n_pos = n_pos + 1'b1;
                        end else if (i_cls.plus || i_cls.minus) begin
                            n_neg   = i_cls.minus;
                            n_pos   = n_pos + 1'b1;
                            n_phase = wcip_pkg::PH_SIGNED;
                        end else begin
                            sign_path = 1'b1;
                        end
                    end
                    wcip_pkg::PH_SIGNED: sign_path = 1'b1;
                    wcip_pkg::PH_ZERO: begin
                        if (i_cls.ex) begin
                            n_pos   = n_pos + 1'b1;
                            n_phase = wcip_pkg::PH_ZEROX;
                        end else begin
                            if (n_base == wcip_pkg::BASE_AUTO) begin
                                n_base = wcip_pkg::BASE_OCT;
                            end
                            do_take = 1'b1;
                        end
                    end
                    wcip_pkg::PH_ZEROX: begin
                        n_base  = wcip_pkg::BASE_HEX;
                        do_take = 1'b1;
                    end
                    default: do_take = 1'b1;
                endcase
            end

            // after an optional sign: a leading zero may open a prefix
            if (sign_path) begin
                if ((n_base == wcip_pkg::BASE_AUTO || n_base == wcip_pkg::BASE_HEX) &&
                    i_cls.zero) begin
                    n_any   = 1'b1;
                    n_acc   = '0;
                    n_pos   = n_pos + 1'b1;
                    n_end   = n_pos;
                    n_phase = wcip_pkg::PH_ZERO;
                end else begin
                    if (n_base == wcip_pkg::BASE_AUTO) begin
                        n_base = wcip_pkg::BASE_DEC;
                    end
                    do_take = 1'b1;
                end
            end

            if (do_take) begin
                w_b = (n_base < wcip_pkg::BASE_MIN || n_base > wcip_pkg::BASE_MAX) ?
                      wcip_pkg::BASE_DEC : n_base;
                w_limit = n_neg ? wcip_pkg::NEG_LIMIT : wcip_pkg::POS_LIMIT;
                // acc*b + d > limit is the same test as acc > (limit - d) / b
                w_sum = wcip_pkg::PROD_W'(n_acc) * wcip_pkg::PROD_W'(w_b) +
                        wcip_pkg::PROD_W'(i_cls.digit);
                if (i_cls.digit >= w_b) begin
                    fin = 1'b1;
                end else begin
                    if (n_ovf) begin
                        n_acc = w_limit;
                    end else if (w_sum > wcip_pkg::PROD_W'(w_limit)) begin
                        n_ovf = 1'b1;
                        n_acc = w_limit;
                    end else begin
                        n_acc = w_sum[wcip_pkg::VAL_W-1:0];
                    end
                    n_any   = 1'b1;
                    n_pos   = n_pos + 1'b1;
                    n_end   = n_pos;
                    n_phase = wcip_pkg::PH_DIGITS;
                end
            end

            if (fin) begin
                w_mag                = n_any ? n_acc : '0;
                o_res_valid          = 1'b1;
                o_res.value          = n_neg ? (wcip_pkg::VAL_W'(0) - w_mag) : w_mag;
                o_res.consumed       = n_any ? n_end : '0;
                o_res.converted      = n_any;
                o_res.range_error    = n_any && n_ovf;
                n_phase              = wcip_pkg::PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wcip_pkg::PH_IDLE;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_end   <= '0;
            r_any   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_any   <= n_any;
        end
    end

    a_idle_no_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != wcip_pkg::PH_IDLE |=> r_phase != wcip_pkg::PH_IDLE)
        else $error("parser fell back to idle");

    a_ovf_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_any)
        else $error("overflow without any digit");

    a_acc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= wcip_pkg::NEG_LIMIT)
        else $error("magnitude beyond saturation limit");

    a_end_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end <= r_pos)
        else $error("end mark past position");

endmodule

`default_nettype wire

// ----- rtl/wide_char_integer_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming wide-character to signed 64-bit integer parser.
// Slave channel: one character per transaction; tuser marks the first
// character of a new string. The string number_base is sampled on that
// first character from the register written through i_cfg_we/i_cfg_wdata
// (reset value 10; 0 auto-detects hex/octal/decimal).
// Master channel: one transaction per ended string, sent on the character that
// ends it (NUL, the first non-digit, the character at the length limit, or
// the first one under an invalid base). Later characters up to the next start produce nothing.
// Path: a character is registered on acceptance, run through the parse
// step and the digit multiply-add once the output register has room, and the
// result of an ending character is loaded into the output register at that
// edge, raising o_m_axis_tvalid.
// Throughput: one character per cycle while the output register is not held,
// set by the combinational multiply-by-radix, add and saturation compare on the accumulator.
// Reset (synchronous, active low) empties both registers, idles the parser
// and loads base 10. While the receiver holds o_m_axis_tvalid without
// i_m_axis_tready, at most one more character is taken into the input
// register and then o_s_axis_tready stays low until the result is taken.
module wide_char_integer_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [20:0] char_code, [23:21] zero
    input  wire logic        i_s_axis_tuser,   // [0] string_start
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // [63:0] parsed_value, [79:64] chars_consumed
    output logic [1:0]       o_m_axis_tuser    // [0] converted, [1] range_error
);

    logic [wcip_pkg::BASE_W-1:0] r_base;
    logic                        r_in_valid;
    logic                        r_in_start;
    wcip_pkg::t_char_class       r_in_cls;
    logic                        r_out_valid;
    wcip_pkg::t_result           r_out;

    wcip_pkg::t_char_class       w_cls;
    logic                        s_accept;
    logic                        proc;
    logic                        res_valid;
    wcip_pkg::t_result           res;

    wcip_classify u_classify (
        .i_char (i_s_axis_tdata[wcip_pkg::CHAR_W-1:0]),
        .o_cls  (w_cls)
    );

    wcip_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc),
        .i_start     (r_in_start),
        .i_cls       (r_in_cls),
        .i_cfg_base  (r_base),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // step the parser only when the output register will have room
    assign proc            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= wcip_pkg::BASE_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_cls   <= w_cls;
            r_in_start <= i_s_axis_tuser;
        end
        if (proc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.consumed, r_out.value};
    assign o_m_axis_tuser  = {r_out.range_error, r_out.converted};

    a_no_step_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !proc)
        else $error("parser stepped while output register is held");

    a_unconverted_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.converted |->
            r_out.value == '0 && r_out.consumed == '0 && !r_out.range_error)
        else $error("nonzero result fields without conversion");

    a_range_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.range_error |->
            r_out.value == wcip_pkg::POS_LIMIT || r_out.value == wcip_pkg::NEG_LIMIT)
        else $error("range error without saturated value");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_in_valid)
        else $error("accepted transaction not held in input register");

endmodule

`default_nettype wire

// ----- dv/wide_char_integer_parser_tb.sv -----
`timescale 1ns / 1ps

module wide_char_integer_parser_tb;

    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int RADIX_PHASES    = 11;

    localparam logic [wcip_pkg::BASE_W-1:0] BAD_BASE_LOW  = 6'd1;
    localparam logic [wcip_pkg::BASE_W-1:0] BAD_BASE_HIGH = 6'd63;

    // Predicts the parse result of each string and matches it against the DUT output.
    class parse_scoreboard;
        logic [wcip_pkg::BASE_W-1:0] radix;
        wcip_pkg::t_phase            phase;
        logic                        negative;
        logic [wcip_pkg::BASE_W-1:0] run_base;
        logic [wcip_pkg::VAL_W-1:0]  magnitude;
        logic                        saturated;
        int unsigned                 position;
        int unsigned                 end_pos;
        logic                        got_digit;
        wcip_pkg::t_result           expected_q[$];
        int                          mismatches;
        int                          results_checked;

        function new();
            radix           = wcip_pkg::BASE_RESET;
            phase           = wcip_pkg::PH_IDLE;
            negative        = 1'b0;
            run_base        = '0;
            magnitude       = '0;
            saturated       = 1'b0;
            position        = 0;
            end_pos         = 0;
            got_digit       = 1'b0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        function int digit_value(logic [wcip_pkg::CHAR_W-1:0] c);
            if (c >= wcip_pkg::CH_0 && c <= wcip_pkg::CH_9)
                return int'(c - wcip_pkg::CH_0);
            if (c >= wcip_pkg::CH_LA && c <= wcip_pkg::CH_LZ)
                return int'(c - wcip_pkg::CH_LA) + 10;
            if (c >= wcip_pkg::CH_UA && c <= wcip_pkg::CH_UZ)
                return int'(c - wcip_pkg::CH_UA) + 10;
            return 99;
        endfunction

        function void close_string();
            wcip_pkg::t_result          r;
            logic [wcip_pkg::VAL_W-1:0] mag;
            mag           = got_digit ? magnitude : '0;
            r.value       = negative ? -mag : mag;
            r.consumed    = got_digit ? wcip_pkg::CNT_W'(end_pos) : '0;
            r.converted   = got_digit;
            r.range_error = got_digit && saturated;
            expected_q.push_back(r);
            phase = wcip_pkg::PH_DONE;
        endfunction

        function void take_digit(logic [wcip_pkg::CHAR_W-1:0] c);
            logic [wcip_pkg::VAL_W-1:0] b;
            logic [wcip_pkg::VAL_W-1:0] d;
            logic [wcip_pkg::VAL_W-1:0] limit;
            b = wcip_pkg::VAL_W'(run_base);
            if (run_base < wcip_pkg::BASE_MIN || run_base > wcip_pkg::BASE_MAX)
                b = wcip_pkg::VAL_W'(wcip_pkg::BASE_DEC);
            d = wcip_pkg::VAL_W'(digit_value(c));
            if (c == wcip_pkg::CH_NUL || d >= b) begin
                close_string();
                return;
            end
            limit = negative ? wcip_pkg::NEG_LIMIT : wcip_pkg::POS_LIMIT;
            // once saturated, further digits are still consumed
            if (saturated) begin
                magnitude = limit;
            end else if (magnitude > (limit - d) / b) begin
                saturated = 1'b1;
                magnitude = limit;
            end else begin
                magnitude = magnitude * b + d;
            end
            got_digit = 1'b1;
            position++;
            end_pos = position;
            phase   = wcip_pkg::PH_DIGITS;
        endfunction

        function void note_input(logic [wcip_pkg::CHAR_W-1:0] c, logic first);
            if (first) begin
                negative  = 1'b0;
                magnitude = '0;
                saturated = 1'b0;
                position  = 0;
                end_pos   = 0;
                got_digit = 1'b0;
                run_base  = radix;
                phase     = wcip_pkg::PH_SPACE;
                if ((run_base != wcip_pkg::BASE_AUTO && run_base < wcip_pkg::BASE_MIN) ||
                    run_base > wcip_pkg::BASE_MAX) begin
                    close_string();
                    return;
                end
            end
            if (phase == wcip_pkg::PH_IDLE || phase == wcip_pkg::PH_DONE) return;
            if (position >= wcip_pkg::MAX_STRING_LEN || c == wcip_pkg::CH_NUL) begin
                close_string();
                return;
            end
            case (phase)
                wcip_pkg::PH_SPACE, wcip_pkg::PH_SIGNED: begin
                    if (phase == wcip_pkg::PH_SPACE && (c == wcip_pkg::CH_SPACE ||
                        (c >= wcip_pkg::CH_TAB && c <= wcip_pkg::CH_CR))) begin
                        position++;
                        return;
                    end
                    if (phase == wcip_pkg::PH_SPACE &&
                        (c == wcip_pkg::CH_PLUS || c == wcip_pkg::CH_MINUS)) begin
                        negative = (c == wcip_pkg::CH_MINUS);
                        position++;
                        phase = wcip_pkg::PH_SIGNED;
                        return;
                    end
                    // a leading zero counts as converted even if "x" follows
                    if ((run_base == wcip_pkg::BASE_AUTO || run_base == wcip_pkg::BASE_HEX) &&
                        c == wcip_pkg::CH_0) begin
                        got_digit = 1'b1;
                        magnitude = '0;
                        position++;
                        end_pos = position;
                        phase   = wcip_pkg::PH_ZERO;
                        return;
                    end
                    if (run_base == wcip_pkg::BASE_AUTO) run_base = wcip_pkg::BASE_DEC;
                    take_digit(c);
                end
                wcip_pkg::PH_ZERO: begin
                    if (c == wcip_pkg::CH_LX || c == wcip_pkg::CH_UX) begin
                        position++;
                        phase = wcip_pkg::PH_ZEROX;
                        return;
                    end
                    if (run_base == wcip_pkg::BASE_AUTO) run_base = wcip_pkg::BASE_OCT;
                    take_digit(c);
                end
                wcip_pkg::PH_ZEROX: begin
                    run_base = wcip_pkg::BASE_HEX;
                    take_digit(c);
                end
                default: take_digit(c);
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [79:0] data, logic [1:0] user);
            wcip_pkg::t_result want;
            results_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result with none pending: value %0d consumed %0d",
                                 $signed(data[63:0]), data[79:64]));
                return;
            end
            want = expected_q.pop_front();
            if (data[63:0] !== want.value)
                report($sformatf("parsed_value %0d, want %0d",
                                 $signed(data[63:0]), $signed(want.value)));
            if (data[79:64] !== want.consumed)
                report($sformatf("chars_consumed %0d, want %0d", data[79:64], want.consumed));
            if (user[0] !== want.converted)
                report($sformatf("converted %0b, want %0b", user[0], want.converted));
            if (user[1] !== want.range_error)
                report($sformatf("range_error %0b, want %0b", user[1], want.range_error));
        endtask
    endclass

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [wcip_pkg::BASE_W-1:0]   cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [23:0]                   s_data    = '0;
    logic                          s_user    = 1'b0;
    logic                          m_valid;
    logic                          m_tready  = 1'b0;
    logic [79:0]                   m_data;
    logic [1:0]                    m_user;

    parse_scoreboard               sb = new();
    logic                          steady = 1'b0;
    int                            holds_requested = 0;
    int                            holds_done = 0;
    int                            hold_left = 0;
    int                            idle_cycles = 0;
    int                            chars_sent = 0;
    int                            base_writes = 0;
    int                            sent_here;
    bit                            paused;
    logic [wcip_pkg::CHAR_W-1:0]   text_q[$];
    logic [wcip_pkg::BASE_W-1:0]   radix_plan[RADIX_PHASES];

    wide_char_integer_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random backpressure, plus one long hold when requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_done != holds_requested) begin
            holds_done <= holds_requested;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) sb.note_input(s_data[wcip_pkg::CHAR_W-1:0], s_user);
            if (m_valid && m_tready) sb.check_result(m_data, m_user);
            if ((s_valid && s_ready) || (m_valid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [wcip_pkg::CHAR_W-1:0] digit_char(int d, bit upper);
        if (d < 10) return wcip_pkg::CH_0 + wcip_pkg::CHAR_W'(d);
        return (upper ? wcip_pkg::CH_UA : wcip_pkg::CH_LA) + wcip_pkg::CHAR_W'(d - 10);
    endfunction

    function automatic logic [wcip_pkg::CHAR_W-1:0] noise_char();
        case ($urandom_range(3))
            0: return wcip_pkg::CHAR_W'($urandom);
            1: return wcip_pkg::CHAR_W'($urandom_range(127));
            2: return wcip_pkg::CHAR_W'($urandom_range(21'h80, 21'h10FFFF));
            default: begin
                case ($urandom_range(4))
                    0: return wcip_pkg::CH_NUL;
                    1: return wcip_pkg::CH_SPACE;
                    2: return wcip_pkg::CH_PLUS;
                    3: return wcip_pkg::CH_MINUS;
                    default: return wcip_pkg::CH_LX;
                endcase
            end
        endcase
    endfunction

    function automatic void push_text(ref logic [wcip_pkg::CHAR_W-1:0] cs[$], input string s);
        for (int i = 0; i < s.len(); i++) cs.push_back(wcip_pkg::CHAR_W'(s[i]));
    endfunction

    // Mostly well-formed numbers with random content; some pure noise.
    function automatic void build_string(input logic [wcip_pkg::BASE_W-1:0] base,
                                         ref logic [wcip_pkg::CHAR_W-1:0] cs[$]);
        int roll;
        int count;
        int eb;
        cs.delete();
        if ($urandom_range(99) < 12) begin
            count = $urandom_range(1, 6);
            repeat (count) cs.push_back(noise_char());
            return;
        end
        count = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (count) begin
            roll = $urandom_range(5);
            cs.push_back(roll == 5 ? wcip_pkg::CH_SPACE :
                                     wcip_pkg::CH_TAB + wcip_pkg::CHAR_W'(roll));
        end
        roll = $urandom_range(2);
        if (roll == 1) cs.push_back(wcip_pkg::CH_PLUS);
        else if (roll == 2) cs.push_back(wcip_pkg::CH_MINUS);
        eb = (base >= wcip_pkg::BASE_MIN && base <= wcip_pkg::BASE_MAX) ? int'(base) : 10;
        if (base == wcip_pkg::BASE_AUTO) begin
            roll = $urandom_range(2);
            if (roll > 0) cs.push_back(wcip_pkg::CH_0);
            if (roll == 2) cs.push_back($urandom_range(1) ? wcip_pkg::CH_UX : wcip_pkg::CH_LX);
            eb = (roll == 0) ? 10 : (roll == 1) ? 8 : 16;
        end else if (base == wcip_pkg::BASE_HEX && $urandom_range(1)) begin
            cs.push_back(wcip_pkg::CH_0);
            cs.push_back($urandom_range(1) ? wcip_pkg::CH_UX : wcip_pkg::CH_LX);
        end
        roll = $urandom_range(99);
        if (eb == 10 && roll < 25) begin
            case ($urandom_range(3))
                0: push_text(cs, "9223372036854775807");
                1: push_text(cs, "9223372036854775808");
                2: push_text(cs, "9223372036854775809");
                default: push_text(cs, "18446744073709551616");
            endcase
        end else if (eb == 16 && roll < 25) begin
            case ($urandom_range(2))
                0: push_text(cs, "7fffffffffffffff");
                1: push_text(cs, "8000000000000000");
                default: push_text(cs, "FFFFFFFFFFFFFFFFF");
            endcase
        end else begin
            count = (roll < 45) ? $urandom_range(12, 30) : $urandom_range(0, 6);
            repeat (count)
                cs.push_back(digit_char(int'($urandom_range(eb - 1)), $urandom_range(1) != 0));
        end
        roll = $urandom_range(9);
        if (roll < 4) cs.push_back(wcip_pkg::CH_NUL);
        else if (roll < 7) cs.push_back(noise_char());
        else if (roll == 7 && eb < 36) cs.push_back(digit_char(eb, $urandom_range(1) != 0));
        // otherwise left open: the next start abandons it
        if ($urandom_range(4) == 0) cs.push_back(noise_char());
    endfunction

    task automatic send_char(input logic [wcip_pkg::CHAR_W-1:0] c, input logic first);
        while (!steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {3'b000, c};
        s_user  <= first;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_chars(input logic [wcip_pkg::CHAR_W-1:0] cs[$]);
        foreach (cs[i]) send_char(cs[i], i == 0);
    endtask

    task automatic send_text(input string s);
        logic [wcip_pkg::CHAR_W-1:0] cs[$];
        push_text(cs, s);
        send_chars(cs);
    endtask

    // step past the accepting edge first so the monitor has noted the last accepted transaction
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    // written once every result is out and the input register has drained
    task automatic write_base(input logic [wcip_pkg::BASE_W-1:0] b);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= b;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.radix = b;
        base_writes++;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before any start: ignored
        send_char(wcip_pkg::CH_9, 1'b0);
        send_char(21'h1FFFFF, 1'b0);
        // all six white-space codes, a sign, a wide-char terminator, then a char after the end
        text_q = {wcip_pkg::CH_TAB, 21'h0A, 21'h0B, 21'h0C, wcip_pkg::CH_CR,
                  wcip_pkg::CH_SPACE};
        push_text(text_q, "-5");
        text_q.push_back(21'h10FFFF);
        text_q.push_back(wcip_pkg::CH_9);
        send_chars(text_q);
        // restart abandons "42"
        send_text("42");
        send_text("9");
        send_char(wcip_pkg::CH_NUL, 1'b0);

        write_base(wcip_pkg::BASE_AUTO);
        send_text("0xg");
        send_text("0X1F");
        send_char(wcip_pkg::CH_NUL, 1'b0);
        send_text("017+");

        write_base(BAD_BASE_LOW);
        send_text("7");

        write_base(wcip_pkg::BASE_MAX);
        send_text("-zzzzzzzzzzzzz!");

        radix_plan = '{wcip_pkg::BASE_DEC, wcip_pkg::BASE_AUTO, wcip_pkg::BASE_HEX,
                       wcip_pkg::BASE_MIN, wcip_pkg::BASE_MAX, wcip_pkg::BASE_OCT,
                       BAD_BASE_LOW, wcip_pkg::BASE_AUTO, BAD_BASE_HIGH,
                       wcip_pkg::BASE_DEC, wcip_pkg::BASE_HEX};
        radix_plan[9] = wcip_pkg::BASE_W'($urandom_range(3, 35));
        paused = 1'b0;
        for (int p = 0; p < RADIX_PHASES; p++) begin
            write_base(radix_plan[p]);
            steady = (p == 3);
            if (p == 1) holds_requested++;
            sent_here = 0;
            while (sent_here < ITEMS_PER_PHASE) begin
                build_string(radix_plan[p], text_q);
                send_chars(text_q);
                sent_here += text_q.size();
                if (p == 7 && !paused && sent_here >= ITEMS_PER_PHASE / 2) begin
                    paused = 1'b1;
                    wait_results();
                end
            end
        end
        steady = 1'b0;

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run: %0d characters, %0d results checked, %0d radix writes incl. auto, 2, 36",
                 chars_sent, sb.results_checked, base_writes);
        $display("and invalid radixes, saturation on both signs and a long output stall.");
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/wcip_pkg.sv
rtl/wcip_classify.sv
rtl/wcip_core.sv
rtl/wide_char_integer_parser.sv
dv/wide_char_integer_parser_tb.sv
